@@ src/fmrt_pkg.sv @@
// fmrt_pkg: constants, register map and sequencer states for the roi tracker
// no dependencies
package fmrt_pkg;

    localparam int MAX_POINTS     = 256;
    localparam int SMOOTH_Q8      = 128;
    localparam int RESET_FRAMES   = 30;
    localparam int NOMINAL_HEIGHT = 200;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int DX_W   = 13;
    localparam int POS_W  = 12;
    localparam int SMOOTH_W = $clog2(SMOOTH_Q8 + 1) + 1;
    localparam int PROD_W = DX_W + SMOOTH_W;
    localparam int VAR_W  = PROD_W - 8;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register map, index = paddr / 4
    localparam logic [2:0] REG_MIN_TRACKED  = 3'd0;
    localparam logic [2:0] REG_MIN_SHIFT    = 3'd1;
    localparam logic [2:0] REG_LOWER_LIMIT  = 3'd2;
    localparam logic [2:0] REG_HOME_X       = 3'd3;
    localparam logic [2:0] REG_HOME_Y       = 3'd4;
    localparam logic [2:0] REG_WINDOW_WIDTH = 3'd5;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SHARE_Q8     = 3'd7;

    localparam logic [8:0]  MIN_TRACKED_RST  = 9'd10;
    localparam logic [11:0] MIN_SHIFT_RST    = 12'd1;
    localparam logic [11:0] LOWER_LIMIT_RST  = 12'd600;
    localparam logic [11:0] HOME_X_RST       = 12'd0;
    localparam logic [11:0] HOME_Y_RST       = 12'd0;
    localparam logic [12:0] WINDOW_WIDTH_RST = 13'd400;
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [8:0]  SHARE_Q8_RST     = 9'd64;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_THRESH,
        ST_DECIDE,
        ST_SCAN,
        ST_SCALE,
        ST_VAR,
        ST_MOVE
    } state_t;

endpackage

@@ src/fmrt_ram.sv @@
// fmrt_ram: generic single-write, single-read ram with registered read data
// no dependencies
module fmrt_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/flow_median_roi_tracker.sv @@
// flow_median_roi_tracker: moves a region-of-interest window by the median shift of points
// depends on fmrt_pkg and fmrt_ram
//
//  channel   ports                                         handshake
//  -------   -----------------------------------------     -----------------------------
//  points    tracked, point_dx, last_point                 start high and busy low
//  result    window_x, window_y, need_refresh, moved,      done high for one cycle
//            went_home
//  config    psel, penable, pwrite, paddr, pwdata,         apb write, pready tied high
//            prdata, pready
//
// a point that is not the last of its frame leaves busy low, so the next point can follow at once
// the last point starts the frame decision: the threshold and decide states,
// then the median in 13 bit passes over the n stored shifts, none when n is 0,
// then the scale, var and move states for scaling and clamping; done rises when the decision ends
// a refresh or idle frame answers from the decide state, with no median passes or scaling
// the median passes, one shift read per cycle from the store ram, set the frame latency
// reset is asynchronous; the shift store is not cleared, only its filled part is read
// the result receiver cannot stall: each result beat is shown for exactly one cycle
module flow_median_roi_tracker (
    input  logic                             clk,
    input  logic                             rst_n,
    // point beats
    input  logic                             start,
    output logic                             busy,
    input  logic                             tracked,
    input  logic signed [fmrt_pkg::DX_W-1:0] point_dx,
    input  logic                             last_point,
    // result beats
    output logic                             done,
    output logic [fmrt_pkg::POS_W-1:0]       window_x,
    output logic [fmrt_pkg::POS_W-1:0]       window_y,
    output logic                             need_refresh,
    output logic                             moved,
    output logic                             went_home,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fmrt_pkg::PADDR_W-1:0]     paddr,
    input  logic [fmrt_pkg::PDATA_W-1:0]     pwdata,
    output logic [fmrt_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    import fmrt_pkg::*;

    // configuration registers
    logic [8:0]  min_tracked_reg;
    logic [11:0] min_shift_reg;
    logic [11:0] lower_limit_reg;
    logic [11:0] home_x_reg;
    logic [11:0] home_y_reg;
    logic [12:0] window_width_reg;
    logic [12:0] frame_width_reg;
    logic [8:0]  share_q8_reg;

    // sequencer and frame state
    state_t state_reg, state_next;
    logic [CNT_W-1:0]  good_reg, good_next;
    logic [CNT_W-1:0]  ind_reg, ind_next;
    logic [POS_W-1:0]  win_x_reg, win_x_next;
    logic [POS_W-1:0]  win_y_reg, win_y_next;
    logic [7:0]        idle_reg, idle_next;
    logic [17:0]       thr_reg, thr_next;

    // median search
    logic [DX_W-1:0]   res_reg, res_next;
    logic [3:0]        bit_reg, bit_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_vld_reg, rd_vld_next;

    // scaling
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [VAR_W-1:0]  var_reg, var_next;

    // result flags
    logic done_reg, done_next;
    logic refresh_reg, refresh_next;
    logic moved_reg, moved_next;
    logic home_reg, home_next;

    // store ram
    logic              st_we;
    logic [DX_W-1:0]   st_rdata;

    // datapath helpers
    logic              accept;
    logic              cfg_wr;
    logic [DX_W-1:0]   mag;
    logic              is_ind;
    logic [DX_W-1:0]   trial;
    logic [DX_W-1:0]   key;
    logic              pass_end;
    logic signed [DX_W-1:0]   med;
    logic signed [PROD_W-1:0] prod_bias;
    logic signed [16:0]       nx;
    logic signed [14:0]       hi;
    logic signed [14:0]       hi_cl;
    logic [POS_W-1:0]         nx_cl;
    logic [14:0]              avar;
    logic [14:0]              ny_sum;
    logic [POS_W-1:0]         ny;
    logic                     push;
    logic [7:0]               idle_inc;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign busy   = (state_reg != ST_COLLECT);

    assign mag    = point_dx[DX_W-1] ? DX_W'(-point_dx) : DX_W'(point_dx);
    assign is_ind = tracked && (mag >= {1'b0, min_shift_reg});
    assign st_we  = accept && is_ind && (ind_reg < CNT_W'(MAX_POINTS));

    fmrt_ram #(
        .WIDTH (DX_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (ind_reg[ADDR_W-1:0]),
        .wdata (point_dx),
        .raddr (addr_reg[ADDR_W-1:0]),
        .rdata (st_rdata)
    );

    // keys are offset binary so an unsigned compare orders signed shifts
    assign trial    = res_reg | (DX_W'(1) << bit_reg);
    assign key      = st_rdata ^ {1'b1, {(DX_W-1){1'b0}}};
    assign pass_end = (addr_reg == ind_reg) && !rd_vld_reg;
    assign med      = $signed(res_reg ^ {1'b1, {(DX_W-1){1'b0}}});

    // truncate toward zero: bias negative products before the shift
    assign prod_bias = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));

    // window moves left by the scaled shift, clamped to the frame
    assign nx    = 17'($signed({1'b0, win_x_reg})) - 17'(var_reg);
    assign hi    = $signed({2'b00, frame_width_reg}) - $signed({2'b00, window_width_reg});
    assign hi_cl = (hi > 15'sd4095) ? 15'sd4095 : hi;

    always_comb
    begin
        if (nx > 17'(hi_cl))
        begin
            nx_cl = (hi_cl < 15'sd0) ? '0 : hi_cl[POS_W-1:0];
        end
        else if (nx < 17'sd0)
        begin
            nx_cl = '0;
        end
        else
        begin
            nx_cl = nx[POS_W-1:0];
        end
    end

    assign avar   = var_reg[VAR_W-1] ? 15'(-var_reg) : 15'(var_reg);
    assign ny_sum = {3'b000, win_y_reg} + avar;
    assign push   = (({1'b0, win_y_reg}) + 13'(NOMINAL_HEIGHT)) < {1'b0, lower_limit_reg};
    assign ny     = (ny_sum <= {3'b000, lower_limit_reg}) ? ny_sum[POS_W-1:0]
                                                          : lower_limit_reg;

    assign idle_inc = (idle_reg != 8'd255) ? idle_reg + 8'd1 : idle_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && last_point)
                begin
                    state_next = ST_THRESH;
                end
            end
            ST_THRESH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (good_reg < min_tracked_reg)
                begin
                    state_next = ST_COLLECT;
                end
                else if ({1'b0, ind_reg} >= thr_reg[17:8])
                begin
                    state_next = (ind_reg == '0) ? ST_SCALE : ST_SCAN;
                end
                else
                begin
                    state_next = ST_COLLECT;
                end
            end
            ST_SCAN:
            begin
                if (pass_end && (bit_reg == 4'd0))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                state_next = ST_COLLECT;
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        good_next    = good_reg;
        ind_next     = ind_reg;
        win_x_next   = win_x_reg;
        win_y_next   = win_y_reg;
        idle_next    = idle_reg;
        thr_next     = thr_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        rd_vld_next  = 1'b0;
        prod_next    = prod_reg;
        var_next     = var_reg;
        done_next    = 1'b0;
        refresh_next = refresh_reg;
        moved_next   = moved_reg;
        home_next    = home_reg;

        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && tracked)
                begin
                    if (good_reg < CNT_W'(MAX_POINTS))
                    begin
                        good_next = good_reg + CNT_W'(1);
                    end
                    if (st_we)
                    begin
                        ind_next = ind_reg + CNT_W'(1);
                    end
                end
            end
            ST_THRESH:
            begin
                thr_next = 18'(good_reg * share_q8_reg);
            end
            ST_DECIDE:
            begin
                res_next  = '0;
                bit_next  = 4'(DX_W - 1);
                addr_next = '0;
                cnt_next  = '0;
                if (good_reg < min_tracked_reg)
                begin
                    done_next    = 1'b1;
                    refresh_next = 1'b1;
                    moved_next   = 1'b0;
                    home_next    = 1'b0;
                    good_next    = '0;
                    ind_next     = '0;
                end
                else if ({1'b0, ind_reg} >= thr_reg[17:8])
                begin
                    // empty set: median is zero, i.e. key at the offset point
                    if (ind_reg == '0)
                    begin
                        res_next = {1'b1, {(DX_W-1){1'b0}}};
                    end
                end
                else
                begin
                    done_next    = 1'b1;
                    refresh_next = 1'b0;
                    moved_next   = 1'b0;
                    idle_next    = idle_inc;
                    home_next    = (idle_inc >= 8'(RESET_FRAMES));
                    if (idle_inc >= 8'(RESET_FRAMES))
                    begin
                        win_x_next = home_x_reg;
                        win_y_next = home_y_reg;
                    end
                    good_next = '0;
                    ind_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg < ind_reg)
                begin
                    addr_next   = addr_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg && (key < trial))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (pass_end)
                begin
                    // keep the bit while fewer than n/2 + 1 shifts lie below it
                    if (cnt_reg <= (ind_reg >> 1))
                    begin
                        res_next = trial;
                    end
                    bit_next  = bit_reg - 4'd1;
                    addr_next = '0;
                    cnt_next  = '0;
                end
            end
            ST_SCALE:
            begin
                prod_next = PROD_W'(med) * PROD_W'(SMOOTH_Q8);
            end
            ST_VAR:
            begin
                var_next = VAR_W'(prod_bias >>> 8);
            end
            ST_MOVE:
            begin
                win_x_next = nx_cl;
                if (push)
                begin
                    win_y_next = ny;
                end
                idle_next    = '0;
                done_next    = 1'b1;
                refresh_next = 1'b0;
                moved_next   = 1'b1;
                home_next    = 1'b0;
                good_next    = '0;
                ind_next     = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            good_reg    <= '0;
            ind_reg     <= '0;
            win_x_reg   <= HOME_X_RST;
            win_y_reg   <= HOME_Y_RST;
            idle_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            refresh_reg <= 1'b0;
            moved_reg   <= 1'b0;
            home_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            good_reg    <= good_next;
            ind_reg     <= ind_next;
            win_x_reg   <= win_x_next;
            win_y_reg   <= win_y_next;
            idle_reg    <= idle_next;
            rd_vld_reg  <= rd_vld_next;
            done_reg    <= done_next;
            refresh_reg <= refresh_next;
            moved_reg   <= moved_next;
            home_reg    <= home_next;
        end
    end

    // search and scaling payload
    always_ff @(posedge clk)
    begin
        thr_reg  <= thr_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        addr_reg <= addr_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        var_reg  <= var_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tracked_reg  <= MIN_TRACKED_RST;
            min_shift_reg    <= MIN_SHIFT_RST;
            lower_limit_reg  <= LOWER_LIMIT_RST;
            home_x_reg       <= HOME_X_RST;
            home_y_reg       <= HOME_Y_RST;
            window_width_reg <= WINDOW_WIDTH_RST;
            frame_width_reg  <= FRAME_WIDTH_RST;
            share_q8_reg     <= SHARE_Q8_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MIN_TRACKED:  min_tracked_reg  <= pwdata[8:0];
                REG_MIN_SHIFT:    min_shift_reg    <= pwdata[11:0];
                REG_LOWER_LIMIT:  lower_limit_reg  <= pwdata[11:0];
                REG_HOME_X:       home_x_reg       <= pwdata[11:0];
                REG_HOME_Y:       home_y_reg       <= pwdata[11:0];
                REG_WINDOW_WIDTH: window_width_reg <= pwdata[12:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[12:0];
                REG_SHARE_Q8:     share_q8_reg     <= pwdata[8:0];
                default:          min_tracked_reg  <= min_tracked_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[4:2])
            REG_MIN_TRACKED:  prdata = 32'(min_tracked_reg);
            REG_MIN_SHIFT:    prdata = 32'(min_shift_reg);
            REG_LOWER_LIMIT:  prdata = 32'(lower_limit_reg);
            REG_HOME_X:       prdata = 32'(home_x_reg);
            REG_HOME_Y:       prdata = 32'(home_y_reg);
            REG_WINDOW_WIDTH: prdata = 32'(window_width_reg);
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_SHARE_Q8:     prdata = 32'(share_q8_reg);
            default:          prdata = '0;
        endcase
    end

    assign done         = done_reg;
    assign window_x     = win_x_reg;
    assign window_y     = win_y_reg;
    assign need_refresh = refresh_reg;
    assign moved        = moved_reg;
    assign went_home    = home_reg;

    // a frame decision always takes busy cycles after its last point
    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_point) |=> busy)
        else $error("last point did not start a decision");

    // each frame flags at most one outcome
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({need_refresh, moved, went_home}))
        else $error("more than one outcome flagged");

    // decisions are separated by at least one point, so beats never touch
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    // a refresh leaves the window where it was
    a_refresh_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && need_refresh) |-> ($stable(window_x) && $stable(window_y)))
        else $error("refresh moved the window");

    // the per-pass count never passes the number of stored shifts
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= ind_reg))
        else $error("median pass count overran");

endmodule

@@ tb/sv/flow_median_roi_tracker_test.sv @@
`timescale 1ns / 1ps
// flow_median_roi_tracker_test: self-checking bench for the roi tracker, points in through
// start/busy, window results checked against a cycle-free model; depends on fmrt_pkg and the rtl
module flow_median_roi_tracker_test;

    import fmrt_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;  // stop limit, far above the slowest legal run
    localparam int DRAIN_CYCLES = 40;       // quiet time before a register write and at the end
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_POINTS  = 36;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             refresh;
        logic             moved;
        logic             home;
    } roi_result_t;

    // dut inputs, all known from time zero
    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    start      = 1'b0;
    logic                    tracked    = 1'b0;
    logic signed [DX_W-1:0]  point_dx   = '0;
    logic                    last_point = 1'b0;
    logic                    psel       = 1'b0;
    logic                    penable    = 1'b0;
    logic                    pwrite     = 1'b0;
    logic [PADDR_W-1:0]      paddr      = '0;
    logic [PDATA_W-1:0]      pwdata     = '0;

    logic                    busy;
    logic                    done;
    logic [POS_W-1:0]        window_x;
    logic [POS_W-1:0]        window_y;
    logic                    need_refresh;
    logic                    moved;
    logic                    went_home;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    // model state: register copy, per-frame counters, stored shifts, window
    int          cfg [8];
    int          shift_log [MAX_POINTS];
    int          good_pts;
    int          indicator_pts;
    int          roi_x;
    int          roi_y;
    int          idle_run;

    roi_result_t pending_windows [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          gaps_on     = 1'b1;

    flow_median_roi_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .tracked      (tracked),
        .point_dx     (point_dx),
        .last_point   (last_point),
        .done         (done),
        .window_x     (window_x),
        .window_y     (window_y),
        .need_refresh (need_refresh),
        .moved        (moved),
        .went_home    (went_home),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // window model: one point beat in, a window result out on the frame's last point
    function automatic bit predict_window(input bit trk, input logic signed [DX_W-1:0] dx,
                                          input bit lst, output roi_result_t res);
        int sdx, mag, med, scaled, nx, hi, ny, i, j, v;
        int sorted_dx [MAX_POINTS];
        sdx = int'(dx);
        res = '0;
        if (trk)
        begin
            mag = (sdx < 0) ? -sdx : sdx;
            if (good_pts < MAX_POINTS)
                good_pts++;
            // shifts past the store's capacity are dropped
            if (mag >= cfg[REG_MIN_SHIFT] && indicator_pts < MAX_POINTS)
            begin
                shift_log[indicator_pts] = sdx;
                indicator_pts++;
            end
        end
        if (!lst)
            return 1'b0;

        if (good_pts < cfg[REG_MIN_TRACKED])
        begin
            res.refresh = 1'b1;
        end
        else if (indicator_pts >= (good_pts * cfg[REG_SHARE_Q8]) / 256)
        begin
            // upper median, zero when no indicator was stored
            med = 0;
            if (indicator_pts > 0)
            begin
                for (i = 0; i < indicator_pts; i++)
                begin
                    v = shift_log[i];
                    j = i;
                    while (j > 0 && sorted_dx[j-1] > v)
                    begin
                        sorted_dx[j] = sorted_dx[j-1];
                        j--;
                    end
                    sorted_dx[j] = v;
                end
                med = sorted_dx[indicator_pts / 2];
            end
            scaled = (med * SMOOTH_Q8) / 256;   // truncates toward zero
            nx = roi_x - scaled;
            hi = cfg[REG_FRAME_WIDTH] - cfg[REG_WINDOW_WIDTH];
            if (hi > 4095)
                hi = 4095;
            if (nx > hi)
                nx = hi;
            if (nx < 0)
                nx = 0;
            roi_x = nx;
            if (roi_y + NOMINAL_HEIGHT < cfg[REG_LOWER_LIMIT])
            begin
                ny = roi_y + ((scaled < 0) ? -scaled : scaled);
                roi_y = (ny <= cfg[REG_LOWER_LIMIT]) ? ny : cfg[REG_LOWER_LIMIT];
            end
            idle_run = 0;
            res.moved = 1'b1;
        end
        else
        begin
            if (idle_run < 255)
                idle_run++;
            if (idle_run >= RESET_FRAMES)
            begin
                roi_x = cfg[REG_HOME_X];
                roi_y = cfg[REG_HOME_Y];
                res.home = 1'b1;
            end
        end
        good_pts = 0;
        indicator_pts = 0;
        res.x = POS_W'(roi_x);
        res.y = POS_W'(roi_y);
        return 1'b1;
    endfunction

    // one point beat; the model runs at the accepting edge
    task automatic send_point(input bit trk, input logic signed [DX_W-1:0] dx, input bit lst);
        roi_result_t res;
        start      <= 1'b1;
        tracked    <= trk;
        point_dx   <= dx;
        last_point <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (predict_window(trk, dx, lst, res))
            pending_windows = {pending_windows, res};
        // sender gap burst
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    // wait for every pending window and a quiet block before touching registers
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_windows.size() != 0 || busy === 1'b1)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // apb write then read back of the same register
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        int          width;
        logic [31:0] masked;
        logic [31:0] rd;
        case (idx)
            REG_MIN_TRACKED, REG_SHARE_Q8:    width = 9;
            REG_WINDOW_WIDTH, REG_FRAME_WIDTH: width = 13;
            default:                          width = 12;
        endcase
        masked = value & ((32'd1 << width) - 32'd1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cfg[idx] = masked;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rd !== masked)
            report_mismatch($sformatf("register %0d read %0d want %0d", idx, rd, masked));
    endtask

    // each register at zero and at all ones, then back to the reset values
    task automatic test_registers();
        settle();
        for (int r = REG_MIN_TRACKED; r <= REG_SHARE_Q8; r++)
        begin
            write_reg(3'(r), 32'd0);
            write_reg(3'(r), 32'hFFFF_FFFF);
        end
        write_reg(REG_MIN_TRACKED, 32'(MIN_TRACKED_RST));
        write_reg(REG_MIN_SHIFT, 32'(MIN_SHIFT_RST));
        write_reg(REG_LOWER_LIMIT, 32'(LOWER_LIMIT_RST));
        write_reg(REG_HOME_X, 32'(HOME_X_RST));
        write_reg(REG_HOME_Y, 32'(HOME_Y_RST));
        write_reg(REG_WINDOW_WIDTH, 32'(WINDOW_WIDTH_RST));
        write_reg(REG_FRAME_WIDTH, 32'(FRAME_WIDTH_RST));
        write_reg(REG_SHARE_Q8, 32'(SHARE_Q8_RST));
    endtask

    // too few good points; the untracked one carries a shift that must be ignored
    task automatic test_refresh();
        settle();
        send_point(1'b1, 13'sd7, 1'b0);
        send_point(1'b0, -13'sd4096, 1'b0);
        send_point(1'b1, 13'sd0, 1'b1);
    endtask

    // largest shifts, an empty indicator set and a frame of untracked points only
    task automatic test_shift_extremes();
        settle();
        write_reg(REG_MIN_TRACKED, 32'd0);
        write_reg(REG_SHARE_Q8, 32'd0);
        write_reg(REG_MIN_SHIFT, 32'd4095);
        send_point(1'b1, 13'sd4095, 1'b0);
        send_point(1'b1, -13'sd4096, 1'b1);
        send_point(1'b1, 13'sd5, 1'b1);
        send_point(1'b0, 13'sd4095, 1'b1);
    endtask

    // narrow frame, column clamp at 4095, no push down, negative truncation
    task automatic test_clamping();
        settle();
        write_reg(REG_MIN_SHIFT, 32'd1);
        write_reg(REG_FRAME_WIDTH, 32'd100);
        write_reg(REG_WINDOW_WIDTH, 32'd400);
        send_point(1'b1, -13'sd4096, 1'b1);
        settle();
        write_reg(REG_FRAME_WIDTH, 32'd8191);
        write_reg(REG_WINDOW_WIDTH, 32'd1);
        send_point(1'b1, -13'sd4096, 1'b1);
        send_point(1'b1, -13'sd4096, 1'b1);
        settle();
        write_reg(REG_LOWER_LIMIT, 32'd0);
        send_point(1'b1, 13'sd100, 1'b1);
        settle();
        write_reg(REG_LOWER_LIMIT, 32'd4095);
        send_point(1'b1, -13'sd3, 1'b1);
    endtask

    // indicator share just below and at the threshold
    task automatic test_share_threshold();
        settle();
        write_reg(REG_SHARE_Q8, 32'd256);
        send_point(1'b1, 13'sd0, 1'b0);
        send_point(1'b1, 13'sd7, 1'b0);
        send_point(1'b1, -13'sd7, 1'b0);
        send_point(1'b1, 13'sd9, 1'b1);
        send_point(1'b1, 13'sd1, 1'b0);
        send_point(1'b1, 13'sd2, 1'b1);
    endtask

    // more points than the store holds, then a short frame to see the counters cleared
    task automatic test_saturation();
        settle();
        write_reg(REG_MIN_TRACKED, 32'd256);
        write_reg(REG_MIN_SHIFT, 32'd0);
        write_reg(REG_SHARE_Q8, 32'd256);
        write_reg(REG_FRAME_WIDTH, 32'd4096);
        write_reg(REG_WINDOW_WIDTH, 32'd400);
        for (int k = 0; k < 300; k++)
            send_point(1'b1, DX_W'($urandom_range(0, 8191)), k == 299);
        for (int k = 0; k < 3; k++)
            send_point(1'b1, DX_W'($urandom_range(0, 8191)), k == 2);
    endtask

    // home registers only matter on a return home; idle count runs past saturation
    task automatic test_long_idle();
        settle();
        write_reg(REG_MIN_TRACKED, 32'd0);
        write_reg(REG_MIN_SHIFT, 32'd1);
        write_reg(REG_SHARE_Q8, 32'd256);
        write_reg(REG_HOME_X, 32'd1234);
        write_reg(REG_HOME_Y, 32'd4095);
        for (int k = 0; k < 270; k++)
            send_point(1'b1, 13'sd0, 1'b1);
        send_point(1'b1, 13'sd40, 1'b1);
        for (int k = 0; k < 31; k++)
            send_point(1'b1, 13'sd0, 1'b1);
    endtask

    // random settings per phase; frames mostly short with a coherent shift and some noise
    task automatic test_random();
        int                     sent;
        int                     len;
        int                     mode;
        int                     base;
        bit                     trk;
        logic signed [DX_W-1:0] dx;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            // last phase runs without sender gaps
            if (phase == RANDOM_PHASES - 1)
                gaps_on = 1'b0;
            write_reg(REG_MIN_TRACKED, ($urandom_range(0, 9) == 0) ? 511 : $urandom_range(0, 8));
            write_reg(REG_MIN_SHIFT, ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 30));
            write_reg(REG_LOWER_LIMIT, $urandom_range(0, 4095));
            write_reg(REG_HOME_X, $urandom_range(0, 4095));
            write_reg(REG_HOME_Y, $urandom_range(0, 4095));
            write_reg(REG_WINDOW_WIDTH,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(100, 800));
            write_reg(REG_FRAME_WIDTH,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(1000, 4096));
            write_reg(REG_SHARE_Q8, ($urandom_range(0, 9) == 0) ? 511 : $urandom_range(0, 160));
            sent = 0;
            while (sent < PHASE_POINTS)
            begin
                // a rare long frame of 200 to 300 points can fill the shift store
                len  = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 300)
                                                    : $urandom_range(1, 20);
                mode = $urandom_range(0, 9);
                base = int'($urandom_range(0, 160)) - 80;
                for (int k = 0; k < len; k++)
                begin
                    // mode 2 frames lose about half their points
                    trk = (mode == 2) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) != 0);
                    if (mode == 0 || $urandom_range(0, 15) == 0)
                        dx = DX_W'($urandom_range(0, 8191));                 // pure noise
                    else if (mode == 1)
                        dx = DX_W'(int'($urandom_range(0, 2)) - 1);          // near standstill
                    else
                        dx = DX_W'(base + int'($urandom_range(0, 8)) - 4);   // coherent motion
                    send_point(trk, dx, k == len - 1);
                end
                sent += len;
            end
        end
    endtask

    // result checker: every done beat against the oldest predicted window
    always @(posedge clk)
    begin : check_results
        roi_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_windows.size() == 0)
            begin
                report_mismatch("window result with none pending");
            end
            else
            begin
                want = pending_windows.pop_front();
                if (window_x !== want.x)
                    report_mismatch($sformatf("window_x got %0d want %0d", window_x, want.x));
                if (window_y !== want.y)
                    report_mismatch($sformatf("window_y got %0d want %0d", window_y, want.y));
                if (need_refresh !== want.refresh)
                    report_mismatch($sformatf("need_refresh got %b want %b",
                                              need_refresh, want.refresh));
                if (moved !== want.moved)
                    report_mismatch($sformatf("moved got %b want %b", moved, want.moved));
                if (went_home !== want.home)
                    report_mismatch($sformatf("went_home got %b want %b", went_home, want.home));
            end
        end
    end

    initial
    begin
        // model at reset
        cfg[REG_MIN_TRACKED]  = int'(MIN_TRACKED_RST);
        cfg[REG_MIN_SHIFT]    = int'(MIN_SHIFT_RST);
        cfg[REG_LOWER_LIMIT]  = int'(LOWER_LIMIT_RST);
        cfg[REG_HOME_X]       = int'(HOME_X_RST);
        cfg[REG_HOME_Y]       = int'(HOME_Y_RST);
        cfg[REG_WINDOW_WIDTH] = int'(WINDOW_WIDTH_RST);
        cfg[REG_FRAME_WIDTH]  = int'(FRAME_WIDTH_RST);
        cfg[REG_SHARE_Q8]     = int'(SHARE_Q8_RST);
        good_pts      = 0;
        indicator_pts = 0;
        roi_x         = int'(HOME_X_RST);
        roi_y         = int'(HOME_Y_RST);
        idle_run      = 0;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        test_refresh();
        test_registers();
        test_shift_extremes();
        test_clamping();
        test_share_threshold();
        test_saturation();
        test_long_idle();
        test_random();

        settle();
        if (pending_windows.size() != 0)
            report_mismatch($sformatf("%0d window results never came", pending_windows.size()));
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
